/* rtl/nocni_pkg.sv */
// shared constants and the result record of the network interface dma
// no dependencies
`default_nettype none

package nocni_pkg;

  // receive queue geometry
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;

  // fixed field widths
  localparam int FLIT_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int FLIT_BYTES = 2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_BASE = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [FLIT_W-1:0] flit_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one result per tick
  typedef struct packed {
    logic       recv_wr_en;
    addr_t      recv_wr_addr;
    flit_t      recv_wr_data;
    addr_t      send_rd_addr;
    logic       out_push;
    flit_t      out_flit;
    logic       intr;
    logic       start_pending;
    logic [2:0] recv_phase;
    logic [1:0] send_phase;
    logic       in_dropped;
  } result_t;

endpackage

`default_nettype wire

/* rtl/noc_network_interface_dma.sv */
// network-on-chip interface with receive and send packet dma machines
// depends on nocni_pkg
`default_nettype none

// usage
//   each transfer on the in_ channel is one tick of the interface: the
//   flit arriving from the router, the processor ack and start request,
//   router room and the send memory word for the previous send_rd_addr
//   each accepted tick yields exactly one transfer on the out_ channel,
//   carrying the receive memory write, send memory read address, router
//   push, interrupt, start flag, machine phases and the drop flag
//   throughput: one tick per clock cycle while in_stall stays low; the receive queue
//   lives in a synchronous memory whose head word is prefetched ahead
//   (with a bypass when the write lands on the new head), so the
//   read-modify-write loop closes without a wait state
//   a result is held in the output register, or in the skid register
//   when the output register is full and not taken; in_stall
//   rises only when both are full, so a stalled receiver costs nothing
//   until two results are waiting
//   cfg_ writes set the receive and send base addresses; write them only
//   while nothing is in flight; a new base applies from the next packet
//   reset (rst_n low, synchronous) empties the queue, returns both
//   machines to ready, clears intr and start and both bases
module noc_network_interface_dma
  import nocni_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration port
  input  wire                  cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [ADDR_W-1:0]    cfg_data,
  // input channel, one tick per transfer
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_in_valid,
  input  wire  [FLIT_W-1:0]    in_in_flit,
  input  wire                  in_ack,
  input  wire                  in_start_set,
  input  wire                  in_out_room,
  input  wire  [FLIT_W-1:0]    in_send_rd_data,
  // result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_recv_wr_en,
  output logic [ADDR_W-1:0]    out_recv_wr_addr,
  output logic [FLIT_W-1:0]    out_recv_wr_data,
  output logic [ADDR_W-1:0]    out_send_rd_addr,
  output logic                 out_out_push,
  output logic [FLIT_W-1:0]    out_out_flit,
  output logic                 out_intr,
  output logic                 out_start_pending,
  output logic [2:0]           out_recv_phase,
  output logic [1:0]           out_send_phase,
  output logic                 out_in_dropped
);

  typedef enum logic [2:0] {
    RX_READY  = 3'd0,
    RX_LENGTH = 3'd1,
    RX_DATA   = 3'd2,
    RX_INTR   = 3'd3,
    RX_FLUSH  = 3'd4
  } rx_state_t;

  typedef enum logic [1:0] {
    TX_READY  = 2'd0,
    TX_LENGTH = 2'd1,
    TX_DATA   = 2'd2
  } tx_state_t;

  // configuration
  addr_t     recv_base_r, send_base_r;

  // machine state
  rx_state_t recv_fsm_r, recv_fsm_nxt;
  tx_state_t send_fsm_r, send_fsm_nxt;
  flit_t     recv_rem_r, recv_rem_nxt;
  flit_t     send_rem_r, send_rem_nxt;
  addr_t     recv_addr_r, recv_addr_nxt;
  addr_t     send_addr_r, send_addr_nxt;
  logic      intr_r, intr_nxt;
  logic      start_r, start_nxt;

  // receive queue
  flit_t     fifo_mem [FIFO_DEPTH];
  flit_t     head_flit_r;          // prefetched word at head_r
  ptr_t      head_r, head_nxt;
  cnt_t      count_r, count_nxt;
  cnt_t      count_pop;
  sum_t      wr_sum;
  ptr_t      fifo_waddr;
  logic      fifo_we;
  logic      pop;

  // result buffering
  result_t   res;
  result_t   out_res_r, skid_res_r;
  logic      out_vld_r, skid_vld_r;
  logic      in_acc, out_take, out_free;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;
  assign out_free = !out_vld_r || out_take;

  // ---------------------------------------------------------------
  // one tick of both machines
  // ---------------------------------------------------------------
  always_comb begin
    res           = '0;
    recv_fsm_nxt  = recv_fsm_r;
    send_fsm_nxt  = send_fsm_r;
    recv_rem_nxt  = recv_rem_r;
    send_rem_nxt  = send_rem_r;
    recv_addr_nxt = recv_addr_r;
    send_addr_nxt = send_addr_r;
    intr_nxt      = intr_r;
    start_nxt     = start_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pop           = 1'b0;
    fifo_we       = 1'b0;
    count_pop     = count_r;
    wr_sum        = '0;
    fifo_waddr    = '0;

    if (in_acc) begin
      if (in_start_set) begin
        start_nxt = 1'b1;
      end

      // receive machine: header, length, payload, then interrupt handshake
      unique case (recv_fsm_r)
        RX_READY: begin
          if (count_r != '0) begin
            pop              = 1'b1;
            res.recv_wr_en   = 1'b1;
            res.recv_wr_addr = recv_base_r;
            res.recv_wr_data = head_flit_r;
            recv_addr_nxt    = recv_base_r + addr_t'(FLIT_BYTES);
            recv_fsm_nxt     = RX_LENGTH;
          end
        end
        RX_LENGTH: begin
          if (count_r != '0) begin
            pop              = 1'b1;
            res.recv_wr_en   = 1'b1;
            res.recv_wr_addr = recv_addr_r;
            res.recv_wr_data = head_flit_r;
            recv_addr_nxt    = recv_addr_r + addr_t'(FLIT_BYTES);
            recv_rem_nxt     = head_flit_r;
            recv_fsm_nxt     = RX_DATA;
          end
        end
        RX_DATA: begin
          if (recv_rem_r == '0) begin
            intr_nxt     = 1'b1;
            recv_fsm_nxt = RX_INTR;
          end else if (count_r != '0) begin
            pop              = 1'b1;
            res.recv_wr_en   = 1'b1;
            res.recv_wr_addr = recv_addr_r;
            res.recv_wr_data = head_flit_r;
            recv_addr_nxt    = recv_addr_r + addr_t'(FLIT_BYTES);
            recv_rem_nxt     = recv_rem_r - flit_t'(1);
          end
        end
        RX_INTR: begin
          if (in_ack) begin
            intr_nxt     = 1'b0;
            recv_fsm_nxt = RX_FLUSH;
          end
        end
        RX_FLUSH: begin
          if (!in_ack) begin
            recv_fsm_nxt = RX_READY;
          end
        end
        default: recv_fsm_nxt = RX_READY;
      endcase

      // send machine: streams words read one tick earlier
      unique case (send_fsm_r)
        TX_READY: begin
          if (start_nxt && in_out_room) begin
            res.out_push  = 1'b1;
            res.out_flit  = in_send_rd_data;
            send_addr_nxt = send_base_r + addr_t'(FLIT_BYTES);
            send_fsm_nxt  = TX_LENGTH;
          end
        end
        TX_LENGTH: begin
          if (in_out_room) begin
            res.out_push  = 1'b1;
            res.out_flit  = in_send_rd_data;
            send_addr_nxt = send_addr_r + addr_t'(FLIT_BYTES);
            send_rem_nxt  = in_send_rd_data;
            send_fsm_nxt  = TX_DATA;
          end
        end
        TX_DATA: begin
          if (send_rem_r == '0) begin
            send_fsm_nxt = TX_READY;
            start_nxt    = 1'b0;   // clear wins over a same-tick request
          end else if (in_out_room) begin
            res.out_push  = 1'b1;
            res.out_flit  = in_send_rd_data;
            send_addr_nxt = send_addr_r + addr_t'(FLIT_BYTES);
            send_rem_nxt  = send_rem_r - flit_t'(1);
          end
        end
        default: send_fsm_nxt = TX_READY;
      endcase

      res.send_rd_addr = (send_fsm_nxt == TX_READY) ? send_base_r : send_addr_nxt;

      // queue pop, then the arriving flit goes in behind it
      if (pop) begin
        head_nxt  = (head_r == ptr_t'(FIFO_DEPTH - 1)) ? '0 : head_r + ptr_t'(1);
        count_pop = count_r - cnt_t'(1);
      end
      count_nxt = count_pop;
      wr_sum    = sum_t'(head_nxt) + sum_t'(count_pop);
      fifo_waddr = (wr_sum >= sum_t'(FIFO_DEPTH)) ? ptr_t'(wr_sum - sum_t'(FIFO_DEPTH))
                                                  : ptr_t'(wr_sum);
      if (in_in_valid) begin
        if (count_pop == cnt_t'(FIFO_DEPTH)) begin
          res.in_dropped = 1'b1;
        end else begin
          fifo_we   = 1'b1;
          count_nxt = count_pop + cnt_t'(1);
        end
      end

      res.intr          = intr_nxt;
      res.start_pending = start_nxt;
      res.recv_phase    = recv_fsm_nxt;
      res.send_phase    = send_fsm_nxt;
    end
  end

  // ---------------------------------------------------------------
  // receive queue memory: write at tail, prefetch the next head word
  // bypass covers a write that lands on the entry being prefetched
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= in_in_flit;
    end
    if (fifo_we && (fifo_waddr == head_nxt)) begin
      head_flit_r <= in_in_flit;
    end else begin
      head_flit_r <= fifo_mem[head_nxt];
    end
  end

  // ---------------------------------------------------------------
  // control state and configuration
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_base_r <= '0;
      send_base_r <= '0;
      recv_fsm_r  <= RX_READY;
      send_fsm_r  <= TX_READY;
      recv_rem_r  <= '0;
      send_rem_r  <= '0;
      recv_addr_r <= '0;
      send_addr_r <= '0;
      intr_r      <= 1'b0;
      start_r     <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_RECV_BASE: recv_base_r <= cfg_data;
          CFG_SEND_BASE: send_base_r <= cfg_data;
          default: ;
        endcase
      end
      recv_fsm_r  <= recv_fsm_nxt;
      send_fsm_r  <= send_fsm_nxt;
      recv_rem_r  <= recv_rem_nxt;
      send_rem_r  <= send_rem_nxt;
      recv_addr_r <= recv_addr_nxt;
      send_addr_r <= send_addr_nxt;
      intr_r      <= intr_nxt;
      start_r     <= start_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  // ---------------------------------------------------------------
  // output register and skid register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || in_acc;
      skid_vld_r <= 1'b0;
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_vld_r ? skid_res_r : res;
    end else if (in_acc) begin
      skid_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_recv_wr_en    = out_res_r.recv_wr_en;
  assign out_recv_wr_addr  = out_res_r.recv_wr_addr;
  assign out_recv_wr_data  = out_res_r.recv_wr_data;
  assign out_send_rd_addr  = out_res_r.send_rd_addr;
  assign out_out_push      = out_res_r.out_push;
  assign out_out_flit      = out_res_r.out_flit;
  assign out_intr          = out_res_r.intr;
  assign out_start_pending = out_res_r.start_pending;
  assign out_recv_phase    = out_res_r.recv_phase;
  assign out_send_phase    = out_res_r.send_phase;
  assign out_in_dropped    = out_res_r.in_dropped;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(FIFO_DEPTH))
    else $error("receive queue fill count beyond depth");

  a_intr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    intr_r |-> (recv_fsm_r == RX_INTR))
    else $error("interrupt raised outside interrupt wait");

  a_send_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    (send_fsm_r != TX_READY) |-> start_r)
    else $error("send machine busy without start flag");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for the noc network interface dma: directed and random ticks,
// each checked against a cycle predictor kept in a small scoreboard class
// depends on nocni_pkg and noc_network_interface_dma
module testbench;
  import nocni_pkg::*;

  // phases of the two packet machines as the block reports them
  typedef enum logic [2:0] {
    RX_READY  = 3'd0,
    RX_LENGTH = 3'd1,
    RX_DATA   = 3'd2,
    RX_INTR   = 3'd3,
    RX_FLUSH  = 3'd4
  } rx_phase_t;

  typedef enum logic [1:0] {
    TX_READY  = 2'd0,
    TX_LENGTH = 2'd1,
    TX_DATA   = 2'd2
  } tx_phase_t;

  // one interface tick, as carried by one input transfer
  typedef struct packed {
    logic  flit_valid;
    flit_t flit;
    logic  ack;
    logic  start_set;
    logic  room;
    flit_t rd_data;
  } tick_t;

  // cycle predictor of both dma machines plus the queue of results still owed
  class tick_scoreboard;
    addr_t     recv_base;
    addr_t     send_base;
    flit_t     rx_queue[$];
    rx_phase_t rx_phase;
    tx_phase_t tx_phase;
    flit_t     rx_left;
    flit_t     tx_left;
    addr_t     rx_addr;
    addr_t     tx_addr;
    logic      intr_flag;
    logic      start_flag;
    result_t   pending_results[$];
    int        errors;
    int        result_no;

    function new();
      recv_base  = '0;
      send_base  = '0;
      rx_phase   = RX_READY;
      tx_phase   = TX_READY;
      rx_left    = '0;
      tx_left    = '0;
      rx_addr    = '0;
      tx_addr    = '0;
      intr_flag  = 1'b0;
      start_flag = 1'b0;
      errors     = 0;
      result_no  = 0;
    endfunction

    // advance the predictor by one accepted tick and queue the result it owes
    function void note_tick(tick_t t);
      result_t r;
      bit      popping;
      bit      pushing;
      r       = '0;
      popping = 1'b0;
      pushing = 1'b0;
      if (t.start_set)
        start_flag = 1'b1;

      // receive machine: at most one flit leaves the queue
      case (rx_phase)
        RX_READY: begin
          if (rx_queue.size() > 0) begin
            rx_addr  = recv_base;
            popping  = 1'b1;
            rx_phase = RX_LENGTH;
          end
        end
        RX_LENGTH: begin
          if (rx_queue.size() > 0) begin
            popping  = 1'b1;
            rx_left  = rx_queue[0];
            rx_phase = RX_DATA;
          end
        end
        RX_DATA: begin
          if (rx_left == 0) begin
            intr_flag = 1'b1;
            rx_phase  = RX_INTR;
          end else if (rx_queue.size() > 0) begin
            popping = 1'b1;
            rx_left = rx_left - 1'b1;
          end
        end
        RX_INTR: begin
          if (t.ack) begin
            intr_flag = 1'b0;
            rx_phase  = RX_FLUSH;
          end
        end
        RX_FLUSH: begin
          if (!t.ack)
            rx_phase = RX_READY;
        end
        default: rx_phase = RX_READY;
      endcase
      if (popping) begin
        r.recv_wr_en   = 1'b1;
        r.recv_wr_addr = rx_addr;
        r.recv_wr_data = rx_queue.pop_front();
        rx_addr        = rx_addr + FLIT_BYTES;
      end

      // send machine: the word read last tick goes to the router
      case (tx_phase)
        TX_READY: begin
          if (start_flag && t.room) begin
            tx_addr  = send_base;
            pushing  = 1'b1;
            tx_phase = TX_LENGTH;
          end
        end
        TX_LENGTH: begin
          if (t.room) begin
            pushing  = 1'b1;
            tx_left  = t.rd_data;
            tx_phase = TX_DATA;
          end
        end
        TX_DATA: begin
          if (tx_left == 0) begin
            tx_phase   = TX_READY;
            start_flag = 1'b0;
          end else if (t.room) begin
            pushing = 1'b1;
            tx_left = tx_left - 1'b1;
          end
        end
        default: tx_phase = TX_READY;
      endcase
      if (pushing) begin
        r.out_push = 1'b1;
        r.out_flit = t.rd_data;
        tx_addr    = tx_addr + FLIT_BYTES;
      end
      r.send_rd_addr = (tx_phase == TX_READY) ? send_base : tx_addr;

      // the arriving flit is queued last, after this tick's pop
      if (t.flit_valid) begin
        if (rx_queue.size() >= FIFO_DEPTH)
          r.in_dropped = 1'b1;
        else
          rx_queue.push_back(t.flit);
      end

      r.intr          = intr_flag;
      r.start_pending = start_flag;
      r.recv_phase    = rx_phase;
      r.send_phase    = tx_phase;
      pending_results.push_back(r);
    endfunction

    // walk the queued flits to tell whether the next one will be read as a length
    function bit wants_length();
      rx_phase_t ph;
      flit_t     left;
      ph   = rx_phase;
      left = rx_left;
      foreach (rx_queue[i]) begin
        if (ph == RX_LENGTH) begin
          left = rx_queue[i];
          ph   = RX_DATA;
        end else if (ph == RX_DATA && left != 0) begin
          left = left - 1'b1;
        end else begin
          ph = RX_LENGTH;
        end
      end
      return ph == RX_LENGTH;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h want %h", result_no, field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with no tick outstanding", result_no));
        result_no++;
        return;
      end
      want = pending_results.pop_front();
      compare("recv_wr_en", got.recv_wr_en, want.recv_wr_en);
      compare("recv_wr_addr", got.recv_wr_addr, want.recv_wr_addr);
      compare("recv_wr_data", got.recv_wr_data, want.recv_wr_data);
      compare("send_rd_addr", got.send_rd_addr, want.send_rd_addr);
      compare("out_push", got.out_push, want.out_push);
      compare("out_flit", got.out_flit, want.out_flit);
      compare("intr", got.intr, want.intr);
      compare("start_pending", got.start_pending, want.start_pending);
      compare("recv_phase", got.recv_phase, want.recv_phase);
      compare("send_phase", got.send_phase, want.send_phase);
      compare("in_dropped", got.in_dropped, want.in_dropped);
      result_no++;
    endtask
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // configuration port
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  addr_t                cfg_data  = '0;

  // input channel: the payload is one tick record, held while stalled
  logic  in_valid = 1'b0;
  logic  in_stall;
  tick_t offered  = '0;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_recv_wr_en;
  addr_t      out_recv_wr_addr;
  flit_t      out_recv_wr_data;
  addr_t      out_send_rd_addr;
  logic       out_out_push;
  flit_t      out_out_flit;
  logic       out_intr;
  logic       out_start_pending;
  logic [2:0] out_recv_phase;
  logic [1:0] out_send_phase;
  logic       out_in_dropped;

  noc_network_interface_dma u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_in_valid       (offered.flit_valid),
    .in_in_flit        (offered.flit),
    .in_ack            (offered.ack),
    .in_start_set      (offered.start_set),
    .in_out_room       (offered.room),
    .in_send_rd_data   (offered.rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_recv_wr_en    (out_recv_wr_en),
    .out_recv_wr_addr  (out_recv_wr_addr),
    .out_recv_wr_data  (out_recv_wr_data),
    .out_send_rd_addr  (out_send_rd_addr),
    .out_out_push      (out_out_push),
    .out_out_flit      (out_out_flit),
    .out_intr          (out_intr),
    .out_start_pending (out_start_pending),
    .out_recv_phase    (out_recv_phase),
    .out_send_phase    (out_send_phase),
    .out_in_dropped    (out_in_dropped)
  );

  tick_scoreboard sb;

  // knobs the main sequence turns between phases
  bit quiet     = 1'b0;  // no idling on either side
  bit hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int flit_pct  = 60;    // chance of a flit arriving on a tick
  int ack_hold  = 0;     // ticks for which the processor withholds ack
  int stall_left = 0;

  // lengths stay short so that packets finish and the machines cycle often
  function automatic flit_t pick_length();
    if ($urandom_range(0, 9) == 0)
      return flit_t'($urandom_range(7, 24));
    return flit_t'($urandom_range(0, 6));
  endfunction

  function automatic flit_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return flit_t'($urandom);
    endcase
  endfunction

  // build the next tick: a well-behaved router, processor and send memory
  // with random content, ack withheld on request so the queue overflows
  function automatic tick_t next_tick();
    tick_t t;
    t.flit_valid = ($urandom_range(0, 99) < flit_pct);
    t.flit       = sb.wants_length() ? pick_length() : pick_word();
    if (ack_hold > 0) begin
      ack_hold--;
      t.ack = 1'b0;
    end else begin
      case (sb.rx_phase)
        RX_INTR:  t.ack = ($urandom_range(0, 2) == 0);
        RX_FLUSH: t.ack = ($urandom_range(0, 2) != 0);
        default:  t.ack = ($urandom_range(0, 9) == 0);
      endcase
    end
    t.start_set = sb.start_flag ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0);
    t.room      = ($urandom_range(0, 4) != 0);
    t.rd_data   = (sb.tx_phase == TX_LENGTH) ? pick_length() : pick_word();
    return t;
  endfunction

  // offer one tick from a rising edge and return at the edge that takes it
  task automatic offer_tick(tick_t t);
    in_valid <= 1'b1;
    offered  <= t;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic directed(logic v, flit_t f, logic ack, logic st, logic room, flit_t rd);
    tick_t t;
    t = '{flit_valid: v, flit: f, ack: ack, start_set: st, room: room, rd_data: rd};
    offer_tick(t);
  endtask

  task automatic run_random(int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      offer_tick(next_tick());
      gap = 0;
      if (!quiet) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: gap = $urandom_range(1, 3);
          4:          gap = $urandom_range(8, 25);
          default:    gap = 0;
        endcase
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // every tick owes one result, so an empty queue means the block is idle
  task automatic wait_drained();
    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both bases, one per cycle, then the predictor follows
  task automatic write_bases(addr_t rx_base, addr_t tx_base);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RECV_BASE;
    cfg_data  <= rx_base;
    @(posedge clk);
    cfg_index <= CFG_SEND_BASE;
    cfg_data  <= tx_base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.recv_base = rx_base;
    sb.send_base = tx_base;
  endtask

  // receiver side: random hold-offs of mostly short length, one long one on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 60;
      end
      if (stall_left == 0 && !quiet) begin
        case ($urandom_range(0, 99)) inside
          [0:19]:  stall_left = $urandom_range(1, 3);
          [20:22]: stall_left = $urandom_range(10, 30);
          default: stall_left = 0;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor: each accepted transfer is checked against the oldest expectation
  result_t seen;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.recv_wr_en    = out_recv_wr_en;
      seen.recv_wr_addr  = out_recv_wr_addr;
      seen.recv_wr_data  = out_recv_wr_data;
      seen.send_rd_addr  = out_send_rd_addr;
      seen.out_push      = out_out_push;
      seen.out_flit      = out_out_flit;
      seen.intr          = out_intr;
      seen.start_pending = out_start_pending;
      seen.recv_phase    = out_recv_phase;
      seen.send_phase    = out_send_phase;
      seen.in_dropped    = out_in_dropped;
      sb.check_result(seen);
    end
  end

  // main sequence
  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bases near the top of the address space so both address streams wrap
    write_bases(32'hFFFF_FFFC, 32'hFFFF_FFFE);

    // packet of length two in, packet of length one out, all-ones and all-zeros words
    directed(1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF);
    directed(1'b1, 16'h0002, 1'b0, 1'b0, 1'b1, 16'h0001);
    directed(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h1234);
    directed(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'h0000);
    // send finishes while start is requested again: the clear must win;
    // ack during the payload is ignored
    directed(1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    directed(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000);
    // interrupt handshake: ack high lowers intr, ack low returns to ready
    directed(1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, 16'h0000);
    directed(1'b1, 16'h8001, 1'b1, 1'b0, 1'b1, 16'h0000);
    // zero-length packets on both sides
    directed(1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h7FFF);
    directed(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000);
    directed(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    directed(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000);
    directed(1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, 16'hAAAA);
    directed(1'b0, 16'h5555, 1'b0, 1'b0, 1'b1, 16'h5555);
    directed(1'b1, 16'hAAAA, 1'b0, 1'b1, 1'b0, 16'hAAAA);
    directed(1'b1, 16'h0001, 1'b0, 1'b0, 1'b1, 16'h0003);
    directed(1'b1, 16'h5555, 1'b0, 1'b0, 1'b1, 16'h5555);
    directed(1'b1, 16'hAAAA, 1'b0, 1'b0, 1'b1, 16'hFFFF);
    in_valid <= 1'b0;
    wait_drained();

    // zero receive base, odd all-ones send base; a stretch with no idling first
    write_bases(32'h0000_0000, 32'hFFFF_FFFF);
    quiet = 1'b1;
    run_random(30);
    quiet = 1'b0;
    run_random(80);
    wait_drained();

    // pressure: ack withheld so the queue overflows, receiver holds off long
    // enough for the block to fill and stall its input
    write_bases(32'hFFFF_FFFF, 32'h0000_0000);
    run_random(40);
    flit_pct = 95;
    ack_hold = 50;
    hold_req = 1'b1;
    run_random(60);
    flit_pct = 60;
    // sender pauses until every result is back, then carries on
    wait_drained();
    run_random(40);
    wait_drained();

    write_bases(addr_t'($urandom), addr_t'($urandom));
    run_random(100);
    wait_drained();

    write_bases(32'h8000_0000, 32'h7FFF_FFFE);
    run_random(100);
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
